>>> design/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and constants of the midpoint line rasterizer
// Port field widths, the request kind code and the pixel record.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int IO_COORD_W = 12;
    localparam int COLOR_W    = 24;

    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    typedef struct packed
    {
        logic                  last;
        logic [COLOR_W-1:0]    color;
        logic [IO_COORD_W-1:0] y;
        logic [IO_COORD_W-1:0] x;
    } pixel_t;

endpackage

>>> design/mlr_line_setup.sv
// ----------------------------------------------------------------------------
// mlr_line_setup: line setup for a load request
// Orders the endpoints along the major axis and derives the initial decision
// value and its straight and diagonal increments.
// ----------------------------------------------------------------------------
module mlr_line_setup
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic [COORD_BITS-1:0]        sx,
    input  logic [COORD_BITS-1:0]        sy,
    input  logic [COORD_BITS-1:0]        ex,
    input  logic [COORD_BITS-1:0]        ey,
    output logic                         x_major,
    output logic                         minor_down,
    output logic [COORD_BITS-1:0]        first_x,
    output logic [COORD_BITS-1:0]        first_y,
    output logic [COORD_BITS-1:0]        major_end,
    output logic signed [COORD_BITS+2:0] decision,
    output logic signed [COORD_BITS+2:0] straight_add,
    output logic signed [COORD_BITS+2:0] diagonal_add
);

    localparam int DW = COORD_BITS + 3;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] ndx;
    logic signed [DW-1:0] ndy;
    logic                 swap;

    assign dx = $signed({3'b000, ex}) - $signed({3'b000, sx});
    assign dy = $signed({3'b000, ey}) - $signed({3'b000, sy});
    assign ax = dx[DW-1] ? -dx : dx;
    assign ay = dy[DW-1] ? -dy : dy;

    assign x_major = (ax >= ay);
    // swap so that the major coordinate increases
    assign swap    = x_major ? (sx > ex) : (sy > ey);
    assign ndx     = swap ? -dx : dx;
    assign ndy     = swap ? -dy : dy;

    assign minor_down = x_major ? ndy[DW-1] : ndx[DW-1];
    assign first_x    = swap ? ex : sx;
    assign first_y    = swap ? ey : sy;
    assign major_end  = x_major ? (swap ? sx : ex) : (swap ? sy : ey);

    assign decision     = x_major ? (ax - (ay <<< 1)) : ((ax <<< 1) - ay);
    assign straight_add = x_major ? -(ay <<< 1) : (ax <<< 1);
    assign diagonal_add = (ax - ay) <<< 1;

endmodule

>>> design/mlr_out_skid.sv
// ----------------------------------------------------------------------------
// mlr_out_skid: pixel output register with one skid entry
// Holds a finished pixel for the consumer and catches one more while stalled.
// ----------------------------------------------------------------------------
module mlr_out_skid
    import mlr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  pixel_t in_data,
    output logic   in_ready,
    output logic   out_valid,
    output pixel_t out_data,
    input  logic   out_ready
);

    logic   out_valid_reg;
    logic   out_valid_next;
    pixel_t out_data_reg;
    pixel_t out_data_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    pixel_t skid_data_reg;
    pixel_t skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                if (in_valid)
                begin
                    out_data_next = in_data;
                end
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> design/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top: integer midpoint line generator
// Load requests set up a line; each step request emits one pixel of it.
// ----------------------------------------------------------------------------
// A step request's pixel is loaded into the output register on accept, or
// into the skid entry while the pixel side stalls. Throughput: one request per
// cycle while s_tready is high; the pixel is computed by one add and compare
// on the line state, which is updated in the same cycle. A one-entry skid
// behind the output register keeps s_tready high until it holds a pixel.
// Reset (rst_n low, asynchronous): idle, no line loaded, output empty.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y,
    // [71:48] line_color
    input  logic [71:0] s_tdata,
    // [0] action (0 load, 1 step)
    input  logic        s_tuser,
    // pixel side
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [47:24] pixel_color
    output logic [47:0] m_tdata,
    // last pixel of the line
    output logic        m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam logic [CB-1:0] COORD_ONE = CB'(1);

    // request fields, resized to the internal coordinate width
    logic [CB+IO_COORD_W-1:0] sx_ext;
    logic [CB+IO_COORD_W-1:0] sy_ext;
    logic [CB+IO_COORD_W-1:0] ex_ext;
    logic [CB+IO_COORD_W-1:0] ey_ext;
    logic [COLOR_W-1:0]       in_color;
    action_t                  in_action;

    assign sx_ext    = {{CB{1'b0}}, s_tdata[11:0]};
    assign sy_ext    = {{CB{1'b0}}, s_tdata[23:12]};
    assign ex_ext    = {{CB{1'b0}}, s_tdata[35:24]};
    assign ey_ext    = {{CB{1'b0}}, s_tdata[47:36]};
    assign in_color  = s_tdata[71:48];
    assign in_action = action_t'(s_tuser);

    // line state
    logic                 busy_reg;
    logic                 busy_next;
    logic                 first_pending_reg;
    logic                 first_pending_next;
    logic                 x_major_reg;
    logic                 x_major_next;
    logic                 minor_down_reg;
    logic                 minor_down_next;
    logic [CB-1:0]        pos_x_reg;
    logic [CB-1:0]        pos_x_next;
    logic [CB-1:0]        pos_y_reg;
    logic [CB-1:0]        pos_y_next;
    logic [CB-1:0]        major_end_reg;
    logic [CB-1:0]        major_end_next;
    logic signed [DW-1:0] decision_reg;
    logic signed [DW-1:0] decision_next;
    logic signed [DW-1:0] straight_reg;
    logic signed [DW-1:0] straight_next;
    logic signed [DW-1:0] diagonal_reg;
    logic signed [DW-1:0] diagonal_next;
    logic [COLOR_W-1:0]   color_reg;
    logic [COLOR_W-1:0]   color_next;

    // setup results for a load
    logic                 ld_x_major;
    logic                 ld_minor_down;
    logic [CB-1:0]        ld_first_x;
    logic [CB-1:0]        ld_first_y;
    logic [CB-1:0]        ld_major_end;
    logic signed [DW-1:0] ld_decision;
    logic signed [DW-1:0] ld_straight;
    logic signed [DW-1:0] ld_diagonal;

    mlr_line_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .sx           (sx_ext[CB-1:0]),
        .sy           (sy_ext[CB-1:0]),
        .ex           (ex_ext[CB-1:0]),
        .ey           (ey_ext[CB-1:0]),
        .x_major      (ld_x_major),
        .minor_down   (ld_minor_down),
        .first_x      (ld_first_x),
        .first_y      (ld_first_y),
        .major_end    (ld_major_end),
        .decision     (ld_decision),
        .straight_add (ld_straight),
        .diagonal_add (ld_diagonal)
    );

    logic                 s_accept;
    logic                 diag;
    logic [CB-1:0]        minor_x;
    logic [CB-1:0]        minor_y;
    logic [CB-1:0]        step_x;
    logic [CB-1:0]        step_y;
    logic signed [DW-1:0] step_decision;
    logic                 step_last;
    logic                 res_valid;
    pixel_t               res_pixel;
    logic [CB+IO_COORD_W-1:0] px_ext;
    logic [CB+IO_COORD_W-1:0] py_ext;
    pixel_t               out_pixel;

    assign s_accept = s_tvalid && s_tready;

    // X major goes diagonal on a negative decision, Y major on a non-negative one
    assign diag    = x_major_reg ? decision_reg[DW-1] : !decision_reg[DW-1];
    assign minor_x = minor_down_reg ? pos_x_reg - COORD_ONE : pos_x_reg + COORD_ONE;
    assign minor_y = minor_down_reg ? pos_y_reg - COORD_ONE : pos_y_reg + COORD_ONE;

    always_comb
    begin
        step_x        = pos_x_reg;
        step_y        = pos_y_reg;
        step_decision = decision_reg;
        // the first step emits the start point unchanged
        if (!first_pending_reg)
        begin
            step_decision = decision_reg + (diag ? diagonal_reg : straight_reg);
            if (x_major_reg)
            begin
                step_x = pos_x_reg + COORD_ONE;
                step_y = diag ? minor_y : pos_y_reg;
            end
            else
            begin
                step_y = pos_y_reg + COORD_ONE;
                step_x = diag ? minor_x : pos_x_reg;
            end
        end
    end

    assign step_last = ((x_major_reg ? step_x : step_y) == major_end_reg);

    always_comb
    begin
        busy_next          = busy_reg;
        first_pending_next = first_pending_reg;
        x_major_next       = x_major_reg;
        minor_down_next    = minor_down_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        major_end_next     = major_end_reg;
        decision_next      = decision_reg;
        straight_next      = straight_reg;
        diagonal_next      = diagonal_reg;
        color_next         = color_reg;
        res_valid          = 1'b0;
        if (s_accept)
        begin
            unique case (in_action)
                ACT_LOAD:
                begin
                    // drop any line in progress and load the new one
                    busy_next          = 1'b1;
                    first_pending_next = 1'b1;
                    x_major_next       = ld_x_major;
                    minor_down_next    = ld_minor_down;
                    pos_x_next         = ld_first_x;
                    pos_y_next         = ld_first_y;
                    major_end_next     = ld_major_end;
                    decision_next      = ld_decision;
                    straight_next      = ld_straight;
                    diagonal_next      = ld_diagonal;
                    color_next         = in_color;
                end
                ACT_STEP:
                begin
                    if (busy_reg)
                    begin
                        res_valid          = 1'b1;
                        first_pending_next = 1'b0;
                        pos_x_next         = step_x;
                        pos_y_next         = step_y;
                        decision_next      = step_decision;
                        busy_next          = !step_last;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            first_pending_reg <= 1'b0;
            x_major_reg       <= 1'b0;
            minor_down_reg    <= 1'b0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            major_end_reg     <= '0;
            decision_reg      <= '0;
            straight_reg      <= '0;
            diagonal_reg      <= '0;
            color_reg         <= '0;
        end
        else
        begin
            busy_reg          <= busy_next;
            first_pending_reg <= first_pending_next;
            x_major_reg       <= x_major_next;
            minor_down_reg    <= minor_down_next;
            pos_x_reg         <= pos_x_next;
            pos_y_reg         <= pos_y_next;
            major_end_reg     <= major_end_next;
            decision_reg      <= decision_next;
            straight_reg      <= straight_next;
            diagonal_reg      <= diagonal_next;
            color_reg         <= color_next;
        end
    end

    // resize the coordinates to the fixed output width
    assign px_ext = {{IO_COORD_W{1'b0}}, step_x};
    assign py_ext = {{IO_COORD_W{1'b0}}, step_y};

    assign res_pixel.x     = px_ext[IO_COORD_W-1:0];
    assign res_pixel.y     = py_ext[IO_COORD_W-1:0];
    assign res_pixel.color = color_reg;
    assign res_pixel.last  = step_last;

    mlr_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res_pixel),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_pixel),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_pixel.color, out_pixel.y, out_pixel.x};
    assign m_tlast = out_pixel.last;

    // a load leaves a line ready to emit its start point
    a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_action == ACT_LOAD) |=> (busy_reg && first_pending_reg))
        else $error("load did not arm the line");

    // the final pixel ends the line
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && step_last) |=> !busy_reg)
        else $error("line still busy after its last pixel");

    // requests stall only while a pixel is held at the output
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("request side stalled with an empty output");

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the midpoint line rasterizer
// Streams load and step requests into the block, predicts every pixel with
// an independent midpoint line tracker and checks each pixel field by field.
// Both stream sides idle at random. One window runs with no idling. Two long
// pixel-side stalls back the block up into the request side.
// ----------------------------------------------------------------------------
module testbench;

    import mlr_pkg::*;

    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int ITEM_TARGET  = 1900;
    localparam int GAP_PCT      = 26;
    localparam int STALL_CYCLES = 90;
    localparam int MAX_COORD    = 4095;

    typedef struct
    {
        action_t     act;
        logic [71:0] data;
    } request_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    midpoint_line_rasterizer_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    request_t request_q[$];       // requests not yet put on the bus
    pixel_t   pixel_expect_q[$];  // predicted pixels, oldest first
    int       req_sent_cnt  = 0;
    int       req_taken_cnt = 0;
    int       err_cnt       = 0;
    int       cyc_cnt       = 0;
    int       quiet_cnt     = 0;
    int       stall_left    = 0;

    // stimulus bookkeeping: pixels still owed by the last queued line
    int       line_px_left  = 0;
    int       useful_cnt    = 0;

    // line tracker of the predictor
    bit          ln_busy;
    bit          ln_first;
    bit          ln_x_major;
    bit          ln_minor_down;
    logic [11:0] ln_x;
    logic [11:0] ln_y;
    logic [11:0] ln_major_end;
    int          ln_dec;
    int          ln_straight;
    int          ln_diag;
    logic [23:0] ln_color;

    // ------------------------------------------------------------------------
    // Clock and reset: hold reset low, then release it on a falling edge
    // ------------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Predictor: advance the line tracker by one request, return its pixel
    // ------------------------------------------------------------------------
    task automatic rasterize_request(input action_t act, input logic [71:0] data,
                                     output bit emit, output pixel_t px);
        int          sx;
        int          sy;
        int          ex;
        int          ey;
        int          dx;
        int          dy;
        int          ax;
        int          ay;
        int          t;
        bit          go_diag;
        logic [11:0] major;
        emit = 1'b0;
        px   = '0;
        if (act == ACT_LOAD)
        begin
            sx = int'(data[11:0]);
            sy = int'(data[23:12]);
            ex = int'(data[35:24]);
            ey = int'(data[47:36]);
            dx = ex - sx;
            dy = ey - sy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax >= ay)
            begin
                ln_x_major = 1'b1;
                // swap so that x increases along the line
                if (sx > ex)
                begin
                    t = sx; sx = ex; ex = t;
                    t = sy; sy = ey; ey = t;
                    dx = -dx;
                    dy = -dy;
                end
                ln_minor_down = (dy < 0);
                ln_dec        = dx - 2 * ay;
                ln_straight   = -2 * ay;
                ln_diag       = 2 * (dx - ay);
                ln_major_end  = ex[11:0];
            end
            else
            begin
                ln_x_major = 1'b0;
                if (sy > ey)
                begin
                    t = sx; sx = ex; ex = t;
                    t = sy; sy = ey; ey = t;
                    dx = -dx;
                    dy = -dy;
                end
                ln_minor_down = (dx < 0);
                ln_dec        = 2 * ax - dy;
                ln_straight   = 2 * ax;
                ln_diag       = 2 * (ax - dy);
                ln_major_end  = ey[11:0];
            end
            ln_x     = sx[11:0];
            ln_y     = sy[11:0];
            ln_color = data[71:48];
            ln_busy  = 1'b1;
            ln_first = 1'b1;
        end
        else if (ln_busy)
        begin
            if (ln_first)
            begin
                // the start point goes out as is
                ln_first = 1'b0;
            end
            else
            begin
                // x-major ties go straight, y-major ties go diagonal
                go_diag = ln_x_major ? (ln_dec < 0) : (ln_dec >= 0);
                ln_dec  = ln_dec + (go_diag ? ln_diag : ln_straight);
                if (ln_x_major)
                begin
                    ln_x = ln_x + 12'd1;
                    if (go_diag)
                        ln_y = ln_minor_down ? ln_y - 12'd1 : ln_y + 12'd1;
                end
                else
                begin
                    ln_y = ln_y + 12'd1;
                    if (go_diag)
                        ln_x = ln_minor_down ? ln_x - 12'd1 : ln_x + 12'd1;
                end
            end
            major    = ln_x_major ? ln_x : ln_y;
            px.x     = ln_x;
            px.y     = ln_y;
            px.color = ln_color;
            px.last  = (major == ln_major_end);
            if (px.last)
                ln_busy = 1'b0;
            emit = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [71:0] random_word();
        logic [95:0] w;
        w = {$urandom, $urandom, $urandom};
        return w[71:0];
    endfunction

    // pick a coordinate within span of c, mirroring the offset if it leaves the screen
    function automatic int near_coord(int c, int span);
        int d;
        d = int'($urandom_range(2 * span)) - span;
        if (c + d < 0 || c + d > MAX_COORD)
            d = -d;
        return c + d;
    endfunction

    task automatic push_load(int sx, int sy, int ex, int ey, logic [23:0] color);
        request_t r;
        int       ax;
        int       ay;
        ax           = (ex > sx) ? ex - sx : sx - ex;
        ay           = (ey > sy) ? ey - sy : sy - ey;
        r.act        = ACT_LOAD;
        r.data       = {color, ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
        line_px_left = ((ax > ay) ? ax : ay) + 1;
        useful_cnt++;
        request_q.push_back(r);
    endtask

    // step fields other than the kind are don't-care; fill them with noise
    task automatic push_steps(int n);
        request_t r;
        repeat (n)
        begin
            r.act  = ACT_STEP;
            r.data = random_word();
            if (line_px_left > 0)
            begin
                line_px_left--;
                useful_cnt++;
            end
            request_q.push_back(r);
        end
    endtask

    // idle roughly GAP_PCT percent of the time, never inside the burst window
    function automatic bit take_gap();
        if (cyc_cnt >= 1800 && cyc_cnt < 2400)
            return 1'b0;
        return $urandom_range(99) < GAP_PCT;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: hold a request until it is taken, then advance
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : req_driver
        request_t r;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (req_sent_cnt != req_taken_cnt)
        begin
            // hold the current request
        end
        else if (request_q.size() != 0 && !take_gap())
        begin
            r = request_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= r.data;
            s_tuser  <= r.act;
            req_sent_cnt++;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Pixel sink: random backpressure plus two long stalls that fill the block
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : pixel_sink
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0 && (cyc_cnt == 700 || cyc_cnt == 1400))
                stall_left = STALL_CYCLES;
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !take_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check pixels against the oldest prediction, predict new requests
    // ------------------------------------------------------------------------
    task automatic report_pixel(bit unexpected, pixel_t want, pixel_t got);
        err_cnt++;
        if (err_cnt <= 10)
        begin
            if (unexpected)
                $display("[%0t] unexpected pixel: x=%0d y=%0d color=%06h last=%0b",
                         $realtime, got.x, got.y, got.color, got.last);
            else
            begin
                $write("[%0t] pixel mismatch: exp x=%0d y=%0d color=%06h last=%0b,",
                       $realtime, want.x, want.y, want.color, want.last);
                $display(" got x=%0d y=%0d color=%06h last=%0b",
                         got.x, got.y, got.color, got.last);
            end
        end
    endtask

    always @(posedge clk)
    begin : monitor
        pixel_t got;
        pixel_t want;
        pixel_t px;
        bit     emit;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tlast, m_tdata};
                if (pixel_expect_q.size() == 0)
                begin
                    report_pixel(1'b1, '0, got);
                end
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.color !== want.color || got.last !== want.last)
                        report_pixel(1'b0, want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                rasterize_request(action_t'(s_tuser), s_tdata, emit, px);
                if (emit)
                    pixel_expect_q.push_back(px);
                req_taken_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no handshake happens for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        cyc_cnt++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cnt = 0;
        end
        else
        begin
            quiet_cnt++;
            if (quiet_cnt == QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int sel;
        int sx;
        int sy;
        int ex;
        int ey;
        int n;
        int span;

        // step with no line loaded: nothing comes out
        push_steps(1);
        // degenerate line: one pixel with last, then a step past the end
        push_load(7, 9, 7, 9, 24'hFFFFFF);
        push_steps(2);
        // x-major with a zero decision on the way (tie goes straight)
        push_load(0, 0, 4, 2, 24'h000000);
        push_steps(5);
        // y-major, endpoints swapped, minor axis moving down, tie goes diagonal
        push_load(2, 4, 4, 0, 24'hA5A5A5);
        push_steps(5);
        // full-screen diagonals and a vertical; each later load drops the line before it
        push_load(MAX_COORD, MAX_COORD, 0, 0, 24'h123456);
        push_steps(2);
        push_load(0, MAX_COORD, MAX_COORD, 0, 24'h5A5A5A);
        push_steps(2);
        push_load(MAX_COORD, 0, MAX_COORD, MAX_COORD, 24'hEDCBA9);

        // random part: mostly complete lines, some cut short, some noise
        while (useful_cnt < ITEM_TARGET)
        begin
            sel = $urandom_range(99);
            if (sel < 6)
            begin
                if ($urandom_range(1))
                    push_steps(1);
                else
                    push_load($urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                              $urandom_range(MAX_COORD), $urandom_range(MAX_COORD),
                              24'($urandom));
            end
            else
            begin
                span = (sel < 10) ? MAX_COORD : ((sel < 14) ? 200 : 20);
                sx = $urandom_range(MAX_COORD);
                sy = $urandom_range(MAX_COORD);
                ex = near_coord(sx, span);
                ey = near_coord(sy, span);
                push_load(sx, sy, ex, ey, 24'($urandom));
                n = line_px_left;
                if (sel < 10)
                    n = $urandom_range(40, 10);  // drop long lines part way
                else if ($urandom_range(99) < 12)
                    n = $urandom_range(n - 1);   // abandon by the next load
                else if ($urandom_range(99) < 10)
                    n = n + $urandom_range(2, 1); // step past the end
                push_steps(n);
            end
        end

        // drain: all requests taken, all pixels seen, then a short settle
        while (request_q.size() != 0 || req_sent_cnt != req_taken_cnt)
            @(posedge clk);
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_cnt == 0 && pixel_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
design/mlr_pkg.sv
design/mlr_line_setup.sv
design/mlr_out_skid.sv
design/midpoint_line_rasterizer_top.sv
tb/sv/testbench.sv
